@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define DRWA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drwa assertion failed");

// expression must never be true outside reset
`define DRWA_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("drwa forbidden condition seen");

`else

`define DRWA_ASSERT(label, clk, rst_n, prop)
`define DRWA_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ sv/drwa_pkg.sv @@
// ----------------------------------------------------------------------------
// drwa_pkg
// types and constants of the duration ring with window average
// ----------------------------------------------------------------------------
package drwa_pkg;

    // ring geometry
    localparam int MAX_DEPTH  = 256;
    localparam int ADDR_W     = $clog2(MAX_DEPTH);
    localparam int LEN_W      = 9;
    localparam int MIN_RING   = 32;
    localparam int MAX_LIST   = 64;
    localparam int IDX_W      = $clog2(MAX_LIST + 1);

    // field widths
    localparam int MODE_W     = 3;
    localparam int ELAPSED_W  = 16;
    localparam int CNT_W      = 9;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;

    // stream and register port widths
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;
    localparam logic [PADDR_W-1:0] REG_RING_LENGTH = '0;
    localparam logic [LEN_W-1:0]   RING_LENGTH_RST = LEN_W'(MAX_DEPTH);

    // sum of a full window and the divider
    localparam int SUM_W      = DATA_W + ADDR_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int REM_W      = CNT_W - 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 3'd0,
        MODE_START  = 3'd1,
        MODE_END    = 3'd2,
        MODE_NEWEST = 3'd3,
        MODE_AVG    = 3'd4,
        MODE_LIST   = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 2'd0,
        STS_START_BUSY = 2'd1,
        STS_END_IDLE   = 2'd2,
        STS_BAD_COUNT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REDUCE,
        ST_AVG,
        ST_DIV,
        ST_AVG_OUT,
        ST_LIST_RD,
        ST_LIST_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [SUM_W-1:0]  a;
        logic [SUM_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0]  res;
        logic              carry;
    } alu_rsp_t;

endpackage

@@ sv/drwa_ram.sv @@
// ----------------------------------------------------------------------------
// drwa_ram
// generic single write port ram with registered, enabled read
// ----------------------------------------------------------------------------
module drwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, holds while not enabled
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/drwa_alu.sv @@
// ----------------------------------------------------------------------------
// drwa_alu
// shared add and subtract unit of the tick, reduce, average and divide steps
// ----------------------------------------------------------------------------
module drwa_alu (
    input  drwa_pkg::alu_req_t req,
    output drwa_pkg::alu_rsp_t rsp
);
    import drwa_pkg::*;

    logic [SUM_W:0] wide;

    // carry is the carry out on add and the borrow on subtract
    always_comb begin
        unique case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = '0;
        endcase
        rsp.res   = wide[SUM_W-1:0];
        rsp.carry = wide[SUM_W];
    end

endmodule

@@ sv/duration_ring_with_window_average_core.sv @@
// ----------------------------------------------------------------------------
// duration_ring_with_window_average_core
// duration capture ring with newest, window average and list queries
// ----------------------------------------------------------------------------
// Input stream (s_*): one request per item, mode selects tick, start, end,
// newest entry, window average or list. Output stream (m_*): one result per
// request, except a list request that returns up to 64 entries, newest first,
// with m_tlast on the final one. Unused modes 6 and 7 return nothing.
// Register ring_length sits at APB address 0 and the user must see that it
// is written only while idle; the block itself does not enforce it. Timing:
// s_tready is high only in idle; a request is decoded in the cycle after
// it is taken. A newest entry and each list entry pass through the
// registered ring read. A list or an average first reduces the head into
// the ring; an average then reads the ring one entry a cycle into the
// shared adder, then the same adder runs a 40 step restoring divide.
// Reset clears the head, the open capture and the ring valid bits, so all
// entries read as zero with no clearing pass. A stalled receiver holds the
// result in the output register and the sequencer waits for it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module duration_ring_with_window_average_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] mode, [18:3] elapsed_us, [27:19] count, [31:28] zero
    input  logic [drwa_pkg::S_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] value, [39:32] position, [41:40] status, [47:42] zero
    output logic [drwa_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drwa_pkg::PADDR_W-1:0]       paddr,
    input  logic [drwa_pkg::PDATA_W-1:0]       pwdata,
    output logic [drwa_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import drwa_pkg::*;

    // configuration
    logic [LEN_W-1:0]      ring_length_reg;
    logic [LEN_W-1:0]      len_used;

    // sequencer
    state_t                state_reg, state_next;

    // latched request
    logic [MODE_W-1:0]     mode_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [CNT_W-1:0]      count_reg;

    // capture state
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic                  measuring_reg, measuring_next;
    logic [DATA_W-1:0]     open_reg, open_next;
    logic [MAX_DEPTH-1:0]  valid_reg;

    // query working registers
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      list_n_reg, list_n_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  vld_q_reg;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]     m_value_reg;
    logic [ADDR_W-1:0]     m_pos_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic                  m_tlast_reg;

    // emit request from the sequencer
    logic                  emit;
    logic [DATA_W-1:0]     emit_value;
    logic [ADDR_W-1:0]     emit_pos;
    status_t               emit_status;
    logic                  emit_last;

    // ring access
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]     entry;

    // shared unit
    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;

    // helpers
    logic                  out_free;
    logic                  cfg_write;
    logic                  bad_count;
    logic [LEN_W-1:0]      head_inc;
    logic [ADDR_W-1:0]     head_wrap;
    logic [ADDR_W-1:0]     ptr_dec;
    logic [REM_W:0]        rem_shift;
    logic                  list_last;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_RING_LENGTH);
    assign prdata    = (paddr == REG_RING_LENGTH) ? PDATA_W'(ring_length_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_length_reg <= RING_LENGTH_RST;
        end else if (cfg_write) begin
            ring_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // ring length clamped to the usable range
    always_comb begin
        if (ring_length_reg < LEN_W'(MIN_RING)) begin
            len_used = LEN_W'(MIN_RING);
        end else if (ring_length_reg > LEN_W'(MAX_DEPTH)) begin
            len_used = LEN_W'(MAX_DEPTH);
        end else begin
            len_used = ring_length_reg;
        end
    end

    // ring storage and shared unit
    drwa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (open_reg),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    drwa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // entries never written read as zero
    assign entry = vld_q_reg ? ram_rdata : '0;

    // small address helpers
    assign head_inc  = LEN_W'(head_reg) + LEN_W'(1);
    assign head_wrap = (head_inc >= len_used) ? '0 : head_inc[ADDR_W-1:0];
    assign ptr_dec   = (ptr_reg == '0) ? ADDR_W'(len_used - LEN_W'(1))
                                       : ptr_reg - ADDR_W'(1);
    assign bad_count = (count_reg == '0) || (count_reg > len_used);
    assign rem_shift = {rem_reg, sum_reg[SUM_W-1]};
    assign list_last = (idx_reg + IDX_W'(1)) == list_n_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    // sequencer next state and datapath control
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        measuring_next = measuring_reg;
        open_next      = open_reg;
        ptr_next       = ptr_reg;
        iss_next       = iss_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        idx_next       = idx_reg;
        list_n_next    = list_n_reg;
        rd_vld_next    = 1'b0;
        alu_req        = '{op: ALU_ADD, a: '0, b: '0};
        ram_we         = 1'b0;
        ram_waddr      = head_wrap;
        ram_re         = 1'b0;
        emit           = 1'b0;
        emit_value     = '0;
        emit_pos       = head_reg;
        emit_status    = STS_OK;
        emit_last      = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE: begin
                unique case (mode_reg)
                    MODE_TICK: begin
                        alu_req = '{op: ALU_ADD, a: SUM_W'(open_reg), b: SUM_W'(elapsed_reg)};
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (measuring_reg) begin
                                // saturate on carry past the duration width
                                open_next = alu_rsp.res[DATA_W] ? '1 : alu_rsp.res[DATA_W-1:0];
                            end
                        end
                    end
                    MODE_START: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (measuring_reg) begin
                                emit_status = STS_START_BUSY;
                            end else begin
                                open_next      = '0;
                                measuring_next = 1'b1;
                            end
                        end
                    end
                    MODE_END: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (!measuring_reg) begin
                                emit_status = STS_END_IDLE;
                            end else begin
                                // advance head first, then store the capture there
                                ram_we         = 1'b1;
                                head_next      = head_wrap;
                                measuring_next = 1'b0;
                                emit_value     = open_reg;
                                emit_pos       = head_wrap;
                            end
                        end
                    end
                    MODE_NEWEST: begin
                        ptr_next    = head_reg;
                        idx_next    = '0;
                        list_n_next = IDX_W'(1);
                        state_next  = ST_LIST_RD;
                    end
                    MODE_AVG, MODE_LIST: begin
                        if (bad_count) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = STS_BAD_COUNT;
                                state_next  = ST_IDLE;
                            end
                        end else begin
                            ptr_next    = head_reg;
                            iss_next    = '0;
                            acc_next    = '0;
                            sum_next    = '0;
                            idx_next    = '0;
                            list_n_next = (count_reg > CNT_W'(MAX_LIST)) ? IDX_W'(MAX_LIST)
                                                                         : count_reg[IDX_W-1:0];
                            state_next  = ST_REDUCE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // bring a head left beyond a shrunk ring back into range
            ST_REDUCE: begin
                alu_req = '{op: ALU_SUB, a: SUM_W'(ptr_reg), b: SUM_W'(len_used)};
                if (alu_rsp.carry) begin
                    state_next = (mode_reg == MODE_AVG) ? ST_AVG : ST_LIST_RD;
                end else begin
                    ptr_next = alu_rsp.res[ADDR_W-1:0];
                end
            end

            // stream reads one per cycle, accumulate the returning entries
            ST_AVG: begin
                if (iss_reg < count_reg) begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    ptr_next    = ptr_dec;
                    iss_next    = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    alu_req  = '{op: ALU_ADD, a: sum_reg, b: SUM_W'(entry)};
                    sum_next = alu_rsp.res;
                    acc_next = acc_reg + CNT_W'(1);
                    if ((acc_reg + CNT_W'(1)) == count_reg) begin
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end

            // restoring divide, quotient shifts into the sum register
            ST_DIV: begin
                alu_req = '{op: ALU_SUB, a: SUM_W'(rem_shift), b: SUM_W'(count_reg)};
                if (!alu_rsp.carry) begin
                    rem_next = alu_rsp.res[REM_W-1:0];
                    sum_next = {sum_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[REM_W-1:0];
                    sum_next = {sum_reg[SUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_AVG_OUT;
                end
            end

            ST_AVG_OUT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_value = sum_reg[DATA_W-1:0];
                    state_next = ST_IDLE;
                end
            end

            ST_LIST_RD: begin
                ram_re     = 1'b1;
                state_next = ST_LIST_OUT;
            end

            ST_LIST_OUT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_value = entry;
                    emit_pos   = ptr_reg;
                    emit_last  = list_last;
                    if (list_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        ptr_next   = ptr_dec;
                        state_next = ST_LIST_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output register valid
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            measuring_reg <= 1'b0;
            open_reg      <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            iss_reg       <= '0;
            acc_reg       <= '0;
            div_cnt_reg   <= '0;
            idx_reg       <= '0;
            list_n_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            measuring_reg <= measuring_next;
            open_reg      <= open_next;
            rd_vld_reg    <= rd_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
            iss_reg       <= iss_next;
            acc_reg       <= acc_next;
            div_cnt_reg   <= div_cnt_next;
            idx_reg       <= idx_next;
            list_n_reg    <= list_n_next;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg    <= s_tdata[MODE_W-1:0];
            elapsed_reg <= s_tdata[MODE_W +: ELAPSED_W];
            count_reg   <= s_tdata[MODE_W + ELAPSED_W +: CNT_W];
        end
        ptr_reg <= ptr_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        if (ram_re) begin
            vld_q_reg <= valid_reg[ptr_reg];
        end
        if (emit) begin
            m_value_reg  <= emit_value;
            m_pos_reg    <= emit_pos;
            m_status_reg <= emit_status;
            m_tlast_reg  <= emit_last;
        end
    end

    // result stream
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {(M_TDATA_W - DATA_W - ADDR_W - STATUS_W)'(0),
                       m_status_reg, m_pos_reg, m_value_reg};

    // divider remainder stays below the divisor
    `DRWA_ASSERT(a_div_rem, aclk, aresetn, (state_reg == ST_DIV) |-> (CNT_W'(rem_reg) < count_reg))
    // window walk stays inside the ring
    `DRWA_ASSERT(a_avg_ptr, aclk, aresetn, (state_reg == ST_AVG) |-> (LEN_W'(ptr_reg) < len_used))
    // never more entries added than read
    `DRWA_ASSERT_NEVER(a_acc_iss, aclk, aresetn, (state_reg == ST_AVG) && (acc_reg > iss_reg))
    // only list results are followed by more results
    `DRWA_ASSERT(a_nonlast_ok, aclk, aresetn, (m_tvalid_reg && !m_tlast_reg) |-> (m_status_reg == STS_OK && (state_reg == ST_LIST_RD || state_reg == ST_LIST_OUT)))
    // a new capture starts from zero
    `DRWA_ASSERT(a_open_clear, aclk, aresetn, $rose(measuring_reg) |-> (open_reg == '0))

endmodule

@@ tb/sv/drwa_result_checker.sv @@
// ----------------------------------------------------------------------------
// drwa_result_checker
// watches both streams and the register port of the duration ring, predicts
// every result of each accepted request and compares it field by field
// ----------------------------------------------------------------------------
module drwa_result_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // [2:0] mode, [18:3] elapsed_us, [27:19] count, [31:28] zero
    input  logic [drwa_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] value, [39:32] position, [41:40] status, [47:42] zero
    input  logic [drwa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [drwa_pkg::PADDR_W-1:0]       paddr,
    input  logic [drwa_pkg::PDATA_W-1:0]       pwdata,
    output int                                 fail_count,
    output int                                 pending_count
);
    import drwa_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [ADDR_W-1:0] position;
        status_t           status;
        logic              last;
    } duration_result_t;

    duration_result_t   expected_durations[$];

    // shadow of the block state
    logic [DATA_W-1:0]  durations [MAX_DEPTH];
    int unsigned        head_idx;
    logic               capture_open;
    logic [DATA_W-1:0]  capture_us;
    logic [LEN_W-1:0]   ring_len_reg;

    function automatic int unsigned clamped_length();
        int unsigned n;
        n = ring_len_reg;
        if (n < MIN_RING) n = MIN_RING;
        if (n > MAX_DEPTH) n = MAX_DEPTH;
        return n;
    endfunction

    // ring index that lies back entries behind the head
    function automatic int unsigned index_back(input int unsigned back, input int unsigned len);
        int unsigned pos;
        if (head_idx >= back) pos = head_idx - back;
        else pos = head_idx + len - back;
        if (pos >= len) pos = pos % len;
        return pos % MAX_DEPTH;
    endfunction

    function automatic void push_expected(input logic [DATA_W-1:0] value, input int unsigned pos,
                                          input status_t status, input logic last);
        duration_result_t r;
        r.value    = value;
        r.position = ADDR_W'(pos);
        r.status   = status;
        r.last     = last;
        expected_durations.push_back(r);
    endfunction

    // apply one request to the shadow state and queue its results
    function automatic void predict_durations(input logic [MODE_W-1:0] mode_bits,
                                              input logic [ELAPSED_W-1:0] elapsed,
                                              input logic [CNT_W-1:0] count);
        int unsigned len;
        int unsigned n;
        int unsigned pos;
        logic [63:0] sum;
        logic [DATA_W:0] widened;
        len = clamped_length();
        case (mode_bits)
            MODE_TICK: begin
                // saturating accumulate while a capture is open
                if (capture_open) begin
                    widened = {1'b0, capture_us} + (DATA_W + 1)'(elapsed);
                    capture_us = widened[DATA_W] ? '1 : widened[DATA_W-1:0];
                end
                push_expected('0, head_idx, STS_OK, 1'b1);
            end
            MODE_START: begin
                if (capture_open) begin
                    push_expected('0, head_idx, STS_START_BUSY, 1'b1);
                end else begin
                    capture_us = '0;
                    capture_open = 1'b1;
                    push_expected('0, head_idx, STS_OK, 1'b1);
                end
            end
            MODE_END: begin
                // head moves before the write
                if (!capture_open) begin
                    push_expected('0, head_idx, STS_END_IDLE, 1'b1);
                end else begin
                    head_idx = head_idx + 1;
                    if (head_idx >= len) head_idx = 0;
                    head_idx = head_idx % MAX_DEPTH;
                    durations[head_idx] = capture_us;
                    capture_open = 1'b0;
                    push_expected(capture_us, head_idx, STS_OK, 1'b1);
                end
            end
            MODE_NEWEST: begin
                pos = head_idx % MAX_DEPTH;
                push_expected(durations[pos], pos, STS_OK, 1'b1);
            end
            MODE_AVG: begin
                if (count == 0 || count > len) begin
                    push_expected('0, head_idx, STS_BAD_COUNT, 1'b1);
                end else begin
                    sum = '0;
                    for (int i = 0; i < count; i++) sum += durations[index_back(i, len)];
                    push_expected(DATA_W'(sum / count), head_idx, STS_OK, 1'b1);
                end
            end
            MODE_LIST: begin
                if (count == 0 || count > len) begin
                    push_expected('0, head_idx, STS_BAD_COUNT, 1'b1);
                end else begin
                    n = (count > MAX_LIST) ? MAX_LIST : count;
                    for (int i = 0; i < n; i++) begin
                        pos = index_back(i, len);
                        push_expected(durations[pos], pos, STS_OK, (i + 1 == n));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // sample everything at the rising edge
    always @(posedge aclk) begin
        duration_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_DEPTH; i++) durations[i] = '0;
            head_idx = 0;
            capture_open = 1'b0;
            capture_us = '0;
            ring_len_reg = RING_LENGTH_RST;
            expected_durations.delete();
            fail_count = 0;
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr == REG_RING_LENGTH)
                ring_len_reg = pwdata[LEN_W-1:0];

            // result compare against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (expected_durations.size() == 0) begin
                    $error("unexpected result: value %0d position %0d status %0d last %0b",
                           m_tdata[31:0], m_tdata[39:32], m_tdata[41:40], m_tlast);
                    fail_count++;
                end else begin
                    want = expected_durations.pop_front();
                    if (m_tdata[31:0] !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[39:32] !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position,
                               m_tdata[39:32]);
                        fail_count++;
                    end
                    if (m_tdata[41:40] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[41:40]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end

            // accepted request
            if (s_tvalid && s_tready)
                predict_durations(s_tdata[2:0], s_tdata[18:3], s_tdata[27:19]);
        end
        pending_count = expected_durations.size();
    end

endmodule

@@ tb/sv/tb_duration_ring_with_window_average_core.sv @@
// ----------------------------------------------------------------------------
// tb_duration_ring_with_window_average_core
// stimulus and verdict for the duration ring with window average
// ----------------------------------------------------------------------------
// Directed requests cover empty reads, every status code, long lists and
// unused modes; random capture sequences and queries follow under several
// ring lengths and idling patterns. A separate checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module tb_duration_ring_with_window_average_core;
    import drwa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // [2:0] mode, [18:3] elapsed_us, [27:19] count, [31:28] zero
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // [31:0] value, [39:32] position, [41:40] status, [47:42] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int                     fail_count;
    int                     pending_count;
    int                     sender_idle_pct;
    int                     receiver_stall_pct;
    int unsigned            used_len;

    duration_ring_with_window_average_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    drwa_result_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("tb_duration_ring_with_window_average_core failed");
        $finish;
    end

    // receiver back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    // one request, with random sender gaps in front of it; entered at a falling edge
    task automatic send_request(input logic [MODE_W-1:0] mode_bits,
                                input logic [ELAPSED_W-1:0] elapsed,
                                input logic [CNT_W-1:0] count);
        while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_W'({count, elapsed, mode_bits});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // register write once the block has gone quiet
    task automatic write_ring_length(input logic [LEN_W-1:0] length);
        wait_drained();
        repeat (32) @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_RING_LENGTH;
        pwdata  = PDATA_W'(length);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (length < MIN_RING) used_len = MIN_RING;
        else if (length > MAX_DEPTH) used_len = MAX_DEPTH;
        else used_len = length;
    endtask

    // start, a few ticks, end
    task automatic send_capture(input int ticks);
        send_request(MODE_START, ELAPSED_W'($urandom), CNT_W'($urandom));
        repeat (ticks) send_request(MODE_TICK, ELAPSED_W'($urandom_range(65535, 0)), '0);
        send_request(MODE_END, ELAPSED_W'($urandom), CNT_W'($urandom));
    endtask

    // mostly well-formed captures and queries, some noise
    task automatic run_random(input int items);
        int sent;
        int pick;
        int ticks;
        logic [MODE_W-1:0] mode_bits;
        logic [CNT_W-1:0] count;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                ticks = $urandom_range(3, 0);
                send_capture(ticks);
                sent += ticks + 2;
            end else if (pick < 85) begin
                mode_bits = MODE_W'($urandom_range(int'(MODE_LIST), int'(MODE_NEWEST)));
                pick = $urandom_range(9, 0);
                if (pick == 0) count = '0;
                else if (pick == 1) count = CNT_W'($urandom_range(511, used_len + 1));
                else if (pick < 5) count = CNT_W'($urandom_range(16, 1));
                else count = CNT_W'($urandom_range(used_len, 1));
                send_request(mode_bits, ELAPSED_W'($urandom), count);
                sent++;
            end else begin
                mode_bits = MODE_W'($urandom_range(7, 0));
                send_request(mode_bits, ELAPSED_W'($urandom), CNT_W'($urandom));
                if (mode_bits <= MODE_LIST) sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        logic [LEN_W-1:0] lengths [6];
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        used_len           = MAX_DEPTH;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // empty ring, idle tick, end while idle, start while measuring
        send_request(MODE_NEWEST, '0, '0);
        send_request(MODE_TICK, 16'hFFFF, '0);
        send_request(MODE_END, '0, '0);
        send_request(MODE_START, '0, '0);
        send_request(MODE_START, '0, '0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_TICK, 16'd1234, '0);
        send_request(MODE_END, '0, '0);
        send_request(MODE_NEWEST, '0, '0);
        send_request(MODE_START, '0, '0);
        send_request(MODE_TICK, 16'hFFFF, '0);
        send_request(MODE_TICK, 16'h8000, '0);
        send_request(MODE_END, '0, '0);

        // bad counts, full window, long list, unused modes
        send_request(MODE_AVG, '0, 9'd0);
        send_request(MODE_AVG, '0, 9'd257);
        send_request(MODE_AVG, '0, 9'h1FF);
        send_request(MODE_LIST, '0, 9'd0);
        send_request(MODE_LIST, '0, 9'd257);
        send_request(MODE_AVG, '0, 9'd2);
        send_request(MODE_AVG, 16'hFFFF, 9'd256);
        send_request(MODE_LIST, '0, 9'd3);
        send_request(MODE_LIST, '0, 9'd256);
        send_request(MODE_SPARE_6, 16'hFFFF, 9'h1FF);
        send_request(MODE_SPARE_7, 16'hFFFF, 9'h1FF);

        // fill the ring so that the head lies beyond a shorter ring later
        repeat (31) send_capture(0);

        lengths = '{9'd32, 9'd0, 9'd100, 9'h1FF, 9'd256, 9'($urandom_range(511, 0))};
        for (int k = 0; k < 6; k++) begin
            write_ring_length(lengths[k]);
            case (k % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 60;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 60;
                end
                default: begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            // head past the shrunk ring wraps by modulo
            if (k == 0) begin
                send_request(MODE_NEWEST, '0, '0);
                send_request(MODE_AVG, '0, 9'd32);
                send_request(MODE_LIST, '0, 9'd32);
            end
            run_random(2);
            wait_drained();
            run_random(2);
        end

        // drain and verdict
        wait_drained();
        repeat (32) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_duration_ring_with_window_average_core passed");
        end else begin
            $display("tb_duration_ring_with_window_average_core failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/drwa_pkg.sv
sv/drwa_ram.sv
sv/drwa_alu.sv
sv/duration_ring_with_window_average_core.sv
tb/sv/drwa_result_checker.sv
tb/sv/tb_duration_ring_with_window_average_core.sv
